// ----- src/ddws_pkg.sv -----
package ddws_pkg;

  localparam int FRAC_BITS_DEF = 8;
  localparam int SPD_W = 16;
  localparam int CFG16_W = 16;
  localparam int LIM_W = 12;
  localparam int RPM_W = 13;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_DIAMETER = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TRACK    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RATIO    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LIMIT    = 2'd3;

  localparam logic [17:0] PI_Q16 = 18'd205887;
  // 60 * 2^16
  localparam logic [21:0] RPM_NUM = 22'd3932160;

  localparam logic [15:0] DIAM_RST  = 16'd1024;
  localparam logic [15:0] TRACK_RST = 16'd3840;
  localparam logic [15:0] RATIO_RST = 16'd256;
  localparam logic [11:0] LIMIT_RST = 12'd600;

  // Magnitude of the doubled wheel speed: fwd*2^(F+1) - turn*track, F <= 16.
  localparam int MAG_W = 35;
  // Divisor widths: den = 2*pi*diam*ratio, 51 bits; max magnitude, 35 bits.
  localparam int NUM_W = 58;
  localparam int DEN_W = 52;
  localparam int Q_W = 13;

  typedef struct packed {
    logic              zero_den;
    logic              scaled;
    logic              neg_l;
    logic              neg_r;
    logic [NUM_W-1:0]  num_l;
    logic [NUM_W-1:0]  num_r;
    logic [DEN_W-1:0]  den;
    logic [LIM_W-1:0]  limit;
  } ddws_job_t;

endpackage

// ----- src/ddws_if.sv -----
interface ddws_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] forward_speed;
  logic signed [15:0] turn_rate;
  modport source (output valid, forward_speed, turn_rate, input ready);
  modport sink (input valid, forward_speed, turn_rate, output ready);
endinterface

interface ddws_out_if;
  logic               valid;
  logic               ready;
  logic signed [12:0] left_motor_rpm;
  logic signed [12:0] right_motor_rpm;
  logic               scaled_down;
  modport source (output valid, left_motor_rpm, right_motor_rpm, scaled_down,
                  input ready);
  modport sink (input valid, left_motor_rpm, right_motor_rpm, scaled_down,
                output ready);
endinterface

// ----- src/differential_drive_wheel_speeds_top.sv -----
// Path: 3 front stages, a two-entry queue and 15 divider stages lie between an
// input transfer and the transfer of its result.
// Throughput: one command per cycle when the output is not stalled; the divider
// computes one quotient bit per stage, so its depth sets the latency and not the rate.
// Reset (rst_n, synchronous, active low) empties every stage and the queue and
// restores diameter 1024, track 3840, ratio 256 and limit 600.
module differential_drive_wheel_speeds_top #(
  parameter int FRAC_BITS = ddws_pkg::FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  ddws_in_if.sink                             in_ch,
  ddws_out_if.source                          out_ch,
  input  logic                                cfg_we,
  input  logic [ddws_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [ddws_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import ddws_pkg::*;

  // Configuration registers; the user must write them only while idle, the block does not enforce it.
  logic [15:0] diam_r, track_r, ratio_r;
  logic [11:0] limit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      diam_r  <= DIAM_RST;
      track_r <= TRACK_RST;
      ratio_r <= RATIO_RST;
      limit_r <= LIMIT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_DIAMETER: diam_r  <= cfg_data;
        REG_TRACK:    track_r <= cfg_data;
        REG_RATIO:    ratio_r <= cfg_data;
        REG_LIMIT:    limit_r <= cfg_data[LIM_W-1:0];
        default: ;
      endcase
    end
  end

  // The front classifies each command (scaled, unscaled or zero divisor)
  // and builds a division job; the queue lets the divider stall on its own.
  ddws_job_t fj, qj;
  logic      fv, fr, qv, qr;

  ddws_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk, .rst_n,
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .fwd(in_ch.forward_speed), .turn(in_ch.turn_rate),
    .diam(diam_r), .track(track_r), .ratio(ratio_r), .limit(limit_r),
    .job_valid(fv), .job_ready(fr), .job(fj)
  );

  ddws_fifo #(.W($bits(ddws_job_t))) u_fifo (
    .clk, .rst_n,
    .wr_valid(fv), .wr_ready(fr), .wr_data(fj),
    .rd_valid(qv), .rd_ready(qr), .rd_data(qj)
  );

  // The back divides with rounding half away from zero, clamps and signs.
  ddws_div u_div (
    .clk, .rst_n,
    .in_valid(qv), .in_ready(qr), .job(qj),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .left_rpm(out_ch.left_motor_rpm), .right_rpm(out_ch.right_motor_rpm),
    .scaled(out_ch.scaled_down)
  );

  assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.scaled_down |-> limit_r != 12'd0 || out_ch.left_motor_rpm == 13'sd0)
    else $error("scaled output above zero limit");
  assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |=> out_ch.valid) else $error("result dropped");
  assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n) |-> !out_ch.valid) else $error("valid after reset");
endmodule

// ----- src/ddws_front.sv -----
module ddws_front #(
  parameter int FRAC_BITS = ddws_pkg::FRAC_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic signed [15:0]  fwd,
  input  logic signed [15:0]  turn,
  input  logic [15:0]         diam,
  input  logic [15:0]         track,
  input  logic [15:0]         ratio,
  input  logic [11:0]         limit,
  output logic                job_valid,
  input  logic                job_ready,
  output ddws_pkg::ddws_job_t job
);
  import ddws_pkg::*;

  // Twice pi in Q16, the constant factor of the divisor.
  localparam logic [18:0] PI2_Q16 = {PI_Q16, 1'b0};

  // Stage 1: speeds and partial products. Stage 2: magnitudes and divisor.
  // Stage 3: limit compare and job build.
  logic               s1_v_r, s2_v_r, s3_v_r;
  logic signed [MAG_W:0] nl_r, nr_r;
  logic [31:0]        dr_r;
  logic [LIM_W-1:0]   lim1_r, lim2_r;
  logic [MAG_W-1:0]   ml_r, mr_r, mmax_r;
  logic               neg_l_r, neg_r_r, zero_den_r;
  logic [DEN_W-1:0]   den_r;
  logic [32+LIM_W-1:0] dl_r;
  ddws_job_t          job_r, job_nxt;
  logic               adv1, adv2, adv3;

  logic signed [MAG_W:0] base, rot;
  logic [MAG_W-1:0]   ml, mr;
  logic [MAG_W+22-1:0] lhs;
  logic [DEN_W+LIM_W-1:0] rhs;

  assign adv3     = !s3_v_r || job_ready;
  assign adv2     = !s2_v_r || adv3;
  assign adv1     = !s1_v_r || adv2;
  assign in_ready = adv1;

  assign base = (MAG_W+1)'(fwd) <<< (FRAC_BITS + 1);
  assign rot  = (MAG_W+1)'(turn) * $signed({1'b0, track});

  assign ml = nl_r[MAG_W] ? MAG_W'(-nl_r) : MAG_W'(nl_r);
  assign mr = nr_r[MAG_W] ? MAG_W'(-nr_r) : MAG_W'(nr_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
    end else begin
      if (adv1) s1_v_r <= in_valid;
      if (adv2) s2_v_r <= s1_v_r;
      if (adv3) s3_v_r <= s2_v_r;
    end
    if (adv1) begin
      nl_r   <= base - rot;
      nr_r   <= base + rot;
      dr_r   <= diam * ratio;
      lim1_r <= limit;
    end
    if (adv2) begin
      ml_r       <= ml;
      mr_r       <= mr;
      mmax_r     <= (ml > mr) ? ml : mr;
      neg_l_r    <= nl_r[MAG_W];
      neg_r_r    <= nr_r[MAG_W];
      zero_den_r <= (dr_r == '0);
      den_r      <= DEN_W'(dr_r) * DEN_W'(PI2_Q16);
      dl_r       <= (32+LIM_W)'(dr_r) * (32+LIM_W)'(lim1_r);
      lim2_r     <= lim1_r;
    end
    if (adv3) job_r <= job_nxt;
  end

  always_comb begin
    lhs  = (MAG_W+22)'(mmax_r) * (MAG_W+22)'(RPM_NUM);
    rhs  = (DEN_W+LIM_W)'(dl_r) * (DEN_W+LIM_W)'(PI2_Q16);
    job_nxt.zero_den = zero_den_r;
    job_nxt.scaled   = !zero_den_r && ((DEN_W+LIM_W)'(lhs) > rhs);
    job_nxt.neg_l    = neg_l_r;
    job_nxt.neg_r    = neg_r_r;
    job_nxt.limit    = lim2_r;
    if (job_nxt.scaled) begin
      job_nxt.num_l = NUM_W'(ml_r) * NUM_W'(lim2_r);
      job_nxt.num_r = NUM_W'(mr_r) * NUM_W'(lim2_r);
      job_nxt.den   = DEN_W'(mmax_r);
    end else begin
      job_nxt.num_l = NUM_W'(ml_r) * NUM_W'(RPM_NUM);
      job_nxt.num_r = NUM_W'(mr_r) * NUM_W'(RPM_NUM);
      job_nxt.den   = den_r;
    end
  end

  assign job_valid = s3_v_r;
  assign job       = job_r;

  assert property (@(posedge clk) disable iff (!rst_n)
    s3_v_r && job_r.scaled |-> !job_r.zero_den) else $error("scaled with zero den");
  assert property (@(posedge clk) disable iff (!rst_n)
    s3_v_r && !job_ready |=> s3_v_r && $stable(job_r)) else $error("job lost");
  assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> adv2 || !s1_v_r) else $error("front overrun");
endmodule

// ----- src/ddws_fifo.sv -----
module ddws_fifo #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         wr_valid,
  output logic         wr_ready,
  input  logic [W-1:0] wr_data,
  output logic         rd_valid,
  input  logic         rd_ready,
  output logic [W-1:0] rd_data
);
  // Two-entry queue.
  logic [W-1:0] mem_r [2];
  logic         wp_r, rp_r;
  logic [1:0]   cnt_r;
  logic         wr, rd;

  assign wr_ready = cnt_r != 2'd2;
  assign rd_valid = cnt_r != 2'd0;
  assign rd_data  = mem_r[rp_r];
  assign wr = wr_valid && wr_ready;
  assign rd = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (wr) wp_r <= !wp_r;
      if (rd) rp_r <= !rp_r;
      cnt_r <= cnt_r + 2'(wr) - 2'(rd);
    end
    if (wr) mem_r[wp_r] <= wr_data;
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 2'd2) else $error("fifo count");
  assert property (@(posedge clk) disable iff (!rst_n)
    wr && !rd |=> cnt_r == $past(cnt_r) + 2'd1) else $error("fifo push");
  assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd0) |-> (wp_r == rp_r)) else $error("fifo ptr");
endmodule

// ----- src/ddws_div.sv -----
module ddws_div (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  ddws_pkg::ddws_job_t      job,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [12:0]       left_rpm,
  output logic signed [12:0]       right_rpm,
  output logic                     scaled
);
  import ddws_pkg::*;

  // Pipelined restoring divider, one quotient bit per stage.
  // Quotient of round(num/den) fits 13 bits after limit clamp; quotients of
  // 2^ST or more saturate to the limit via an overflow flag.
  localparam int ST = Q_W + 1;
  localparam int RW = DEN_W + 1;

  logic               v_r   [ST+1];
  ddws_job_t          j_r   [ST+1];
  logic [RW-1:0]      rl_r  [ST+1];
  logic [RW-1:0]      rr_r  [ST+1];
  logic [ST-1:0]      ql_r  [ST+1];
  logic [ST-1:0]      qr_r  [ST+1];
  logic               ovl_r [ST+1];
  logic               ovr_r [ST+1];
  logic               adv;
  logic               ovl0, ovr0;
  logic [NUM_W:0]     n2l, n2r;
  logic [DEN_W:0]     d2;
  logic [Q_W-1:0]     mag_l, mag_r;
  logic [ST-1:0]      ql, qr;

  assign adv      = !v_r[ST] || out_ready;
  assign in_ready = adv;

  // Divide (2n+d) by 2d. Overflow if quotient >= 2^ST.
  assign n2l  = {job.num_l, 1'b0} + (NUM_W+1)'(job.den);
  assign n2r  = {job.num_r, 1'b0} + (NUM_W+1)'(job.den);
  assign d2   = {job.den, 1'b0};
  assign ovl0 = (n2l >> ST) >= (NUM_W+1)'(d2);
  assign ovr0 = (n2r >> ST) >= (NUM_W+1)'(d2);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i <= ST; i++) v_r[i] <= 1'b0;
    end else if (adv) begin
      v_r[0] <= in_valid;
      for (int i = 1; i <= ST; i++) v_r[i] <= v_r[i-1];
    end
  end

  logic [NUM_W:0] nl_r [ST+1];
  logic [NUM_W:0] nr_r [ST+1];

  // The upper bits of the dividend seed the partial remainder; the low ST
  // bits are shifted in one per stage.
  always_ff @(posedge clk) begin
    if (adv) begin
      j_r[0]   <= job;
      nl_r[0]  <= n2l;
      nr_r[0]  <= n2r;
      rl_r[0]  <= RW'(n2l >> ST);
      rr_r[0]  <= RW'(n2r >> ST);
      ql_r[0]  <= '0;
      qr_r[0]  <= '0;
      ovl_r[0] <= ovl0;
      ovr_r[0] <= ovr0;
      for (int i = 1; i <= ST; i++) begin
        logic [RW:0] tl, tr;
        tl = {rl_r[i-1], nl_r[i-1][ST-i]};
        tr = {rr_r[i-1], nr_r[i-1][ST-i]};
        j_r[i]   <= j_r[i-1];
        nl_r[i]  <= nl_r[i-1];
        nr_r[i]  <= nr_r[i-1];
        ovl_r[i] <= ovl_r[i-1];
        ovr_r[i] <= ovr_r[i-1];
        if (tl >= (RW+1)'({j_r[i-1].den, 1'b0})) begin
          rl_r[i] <= RW'(tl - (RW+1)'({j_r[i-1].den, 1'b0}));
          ql_r[i] <= {ql_r[i-1][ST-2:0], 1'b1};
        end else begin
          rl_r[i] <= RW'(tl);
          ql_r[i] <= {ql_r[i-1][ST-2:0], 1'b0};
        end
        if (tr >= (RW+1)'({j_r[i-1].den, 1'b0})) begin
          rr_r[i] <= RW'(tr - (RW+1)'({j_r[i-1].den, 1'b0}));
          qr_r[i] <= {qr_r[i-1][ST-2:0], 1'b1};
        end else begin
          rr_r[i] <= RW'(tr);
          qr_r[i] <= {qr_r[i-1][ST-2:0], 1'b0};
        end
      end
    end
  end

  always_comb begin
    ql = ql_r[ST];
    qr = qr_r[ST];
    if (j_r[ST].zero_den) begin
      mag_l = '0;
      mag_r = '0;
    end else begin
      mag_l = (ovl_r[ST] || ql > ST'(j_r[ST].limit)) ? Q_W'(j_r[ST].limit) : Q_W'(ql);
      mag_r = (ovr_r[ST] || qr > ST'(j_r[ST].limit)) ? Q_W'(j_r[ST].limit) : Q_W'(qr);
    end
    left_rpm  = j_r[ST].neg_l ? -$signed(mag_l) : $signed(mag_l);
    right_rpm = j_r[ST].neg_r ? -$signed(mag_r) : $signed(mag_r);
  end

  assign out_valid = v_r[ST];
  assign scaled    = j_r[ST].scaled;

  assert property (@(posedge clk) disable iff (!rst_n)
    v_r[ST] && j_r[ST].zero_den |-> left_rpm == 13'sd0) else $error("zero den out");
  assert property (@(posedge clk) disable iff (!rst_n)
    v_r[ST] && !out_ready |=> v_r[ST]) else $error("div output lost");
  assert property (@(posedge clk) disable iff (!rst_n)
    v_r[ST] |-> mag_l <= Q_W'(j_r[ST].limit)) else $error("clamp");
endmodule

// ----- verif/differential_drive_wheel_speeds_top_tb.sv -----
`timescale 1ns / 1ps

module differential_drive_wheel_speeds_top_tb;
  import ddws_pkg::*;

  // The timeout is far above the slowest correct run, even with 62 percent
  // stalls on either side and the long hold for about 550 commands.
  localparam int CYCLE_LIMIT = 400000;
  // Extra cycles are allowed after the queue of expected results empties.
  localparam int SETTLE_CYCLES = 40;
  localparam int HOLD_CYCLES = 150;

  typedef struct {
    logic signed [12:0] left_rpm;
    logic signed [12:0] right_rpm;
    logic               scaled;
  } wheel_rpm_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  ddws_in_if  cmd_bus ();
  ddws_out_if rpm_bus ();

  differential_drive_wheel_speeds_top uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (cmd_bus),
    .out_ch   (rpm_bus),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // This is the testbench copy of the configuration registers. It is
  // updated when each register write is issued.
  logic [15:0] diam_q;
  logic [15:0] track_q;
  logic [15:0] ratio_q;
  logic [11:0] limit_q;

  wheel_rpm_t expected_rpm[$];
  int  error_count = 0;
  int  cycle_count = 0;
  int  tx_idle_pct = 0;
  int  rx_stall_pct = 0;
  logic hold_req;
  logic hold_on;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // This function computes the expected wheel rpm for one command. The
  // doubled wheel speed is formed exactly. The limit test and both divisions
  // are done on exact integers. Rounding is half away from zero.
  function automatic wheel_rpm_t predict_wheel_rpm(input logic signed [15:0] fwd,
                                                   input logic signed [15:0] turn);
    longint base, rot, nl, nr;
    longint unsigned ml, mr, mmax, den, rl, rr, rpm_num;
    wheel_rpm_t res;
    rpm_num = longint'(RPM_NUM);
    base = longint'(fwd) * 512;
    rot  = longint'(turn) * longint'({1'b0, track_q});
    nl = base - rot;
    nr = base + rot;
    ml = (nl < 0) ? -nl : nl;
    mr = (nr < 0) ? -nr : nr;
    mmax = (ml > mr) ? ml : mr;
    den = 2 * longint'(PI_Q16) * longint'({1'b0, diam_q}) * longint'({1'b0, ratio_q});
    res.scaled = 1'b0;
    if (den == 0) begin
      rl = 0;
      rr = 0;
    end else if (mmax * rpm_num > longint'({1'b0, limit_q}) * den) begin
      // Both sides are scaled by limit / max so that the curvature is kept.
      res.scaled = 1'b1;
      rl = (2 * limit_q * ml + mmax) / (2 * mmax);
      rr = (2 * limit_q * mr + mmax) / (2 * mmax);
    end else begin
      rl = (2 * ml * rpm_num + den) / (2 * den);
      rr = (2 * mr * rpm_num + den) / (2 * den);
    end
    if (rl > limit_q) rl = limit_q;
    if (rr > limit_q) rr = limit_q;
    res.left_rpm  = (nl < 0) ? -rl[12:0] : rl[12:0];
    res.right_rpm = (nr < 0) ? -rr[12:0] : rr[12:0];
    return res;
  endfunction

  // Every accepted command is predicted at the edge where it is accepted.
  always @(posedge clk) begin
    if (rst_n && cmd_bus.valid && cmd_bus.ready)
      expected_rpm.push_back(predict_wheel_rpm(cmd_bus.forward_speed, cmd_bus.turn_rate));
  end

  // Each result transfer is compared with the oldest pending prediction.
  always @(posedge clk) begin
    wheel_rpm_t exp_r;
    if (rst_n && rpm_bus.valid && rpm_bus.ready) begin
      if (expected_rpm.size() == 0) begin
        error_count++;
        $display("%0t: unexpected result L=%0d R=%0d S=%0b", $time,
                 rpm_bus.left_motor_rpm, rpm_bus.right_motor_rpm, rpm_bus.scaled_down);
      end else begin
        exp_r = expected_rpm.pop_front();
        if (rpm_bus.left_motor_rpm !== exp_r.left_rpm) begin
          error_count++;
          $display("%0t: left rpm expected %0d actual %0d", $time,
                   exp_r.left_rpm, rpm_bus.left_motor_rpm);
        end
        if (rpm_bus.right_motor_rpm !== exp_r.right_rpm) begin
          error_count++;
          $display("%0t: right rpm expected %0d actual %0d", $time,
                   exp_r.right_rpm, rpm_bus.right_motor_rpm);
        end
        if (rpm_bus.scaled_down !== exp_r.scaled) begin
          error_count++;
          $display("%0t: scaled flag expected %0b actual %0b", $time,
                   exp_r.scaled, rpm_bus.scaled_down);
        end
      end
    end
  end

  // The long hold is counted here, apart from the random receiver stalls.
  initial begin
    hold_on = 1'b0;
    wait (hold_req === 1'b1);
    hold_on <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_on <= 1'b0;
  end

  // Receiver side. A long hold overrides the random stalls. During the hold
  // the pipeline fills and the block has to push back on the sender.
  always @(posedge clk) begin
    if (!rst_n) begin
      rpm_bus.ready <= 1'b0;
    end else if (hold_on) begin
      rpm_bus.ready <= 1'b0;
    end else begin
      rpm_bus.ready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // This task offers one command and returns after its transfer. Valid stays
  // high into the next command unless a random idle gap is drawn.
  task automatic send_command(input logic [15:0] fwd, input logic [15:0] turn);
    int gap;
    cmd_bus.valid <= 1'b1;
    cmd_bus.forward_speed <= fwd;
    cmd_bus.turn_rate <= turn;
    @(posedge clk);
    while (!cmd_bus.ready) @(posedge clk);
    if ($urandom_range(99) < tx_idle_pct) begin
      gap = $urandom_range(1, 6);
      cmd_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_idle();
    cmd_bus.valid <= 1'b0;
    @(posedge clk);
    while (expected_rpm.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Bits above a register's width are filled with random values. The block
  // must ignore those bits.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      REG_DIAMETER: diam_q = val;
      REG_TRACK:    track_q = val;
      REG_RATIO:    ratio_q = val;
      REG_LIMIT:    limit_q = val[11:0];
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_geometry(input logic [15:0] d, input logic [15:0] t,
                              input logic [15:0] r, input logic [11:0] lim);
    write_reg(REG_DIAMETER, d);
    write_reg(REG_TRACK, t);
    write_reg(REG_RATIO, r);
    write_reg(REG_LIMIT, {4'($urandom_range(15)), lim});
  endtask

  // Half of the commands use moderate speeds, so both the unscaled path and the
  // scaled path are reached. The rest use the full 16-bit range.
  task automatic send_random(input int count);
    logic [15:0] f, t;
    repeat (count) begin
      if ($urandom_range(1)) begin
        f = $urandom;
        t = $urandom;
      end else begin
        f = 16'($signed(12'($urandom)));
        t = 16'($signed(10'($urandom)));
      end
      send_command(f, t);
    end
  endtask

  // These are the extreme commands and the zero command. They run at the
  // current setting.
  task automatic test_extremes();
    send_command(16'h0000, 16'h0000);
    send_command(16'h7FFF, 16'h0000);
    send_command(16'h8000, 16'h0000);
    send_command(16'h0000, 16'h7FFF);
    send_command(16'h0000, 16'h8000);
    send_command(16'h7FFF, 16'h7FFF);
    send_command(16'h8000, 16'h8000);
    send_command(16'h7FFF, 16'h8000);
    send_command(16'h8000, 16'h7FFF);
    send_command(16'h0100, 16'h0000);
    send_command(16'h0001, 16'h0000);
    send_command(16'hFFFF, 16'h0000);
    send_command(16'h4000, 16'h0040);
    send_command(16'hC000, 16'hFFC0);
    wait_idle();
  endtask

  // A zero diameter or a zero ratio forces both outputs to zero without
  // scaling. A zero limit scales every nonzero speed down to zero.
  task automatic test_special_settings();
    set_geometry(16'd0, 16'd3840, 16'd256, 12'd600);
    send_command(16'h7FFF, 16'h1234);
    send_command(16'h8000, 16'h8000);
    wait_idle();
    set_geometry(16'd1024, 16'd3840, 16'd0, 12'd600);
    send_command(16'h7FFF, 16'h1234);
    send_command(16'h0100, 16'hFF00);
    wait_idle();
    set_geometry(16'd1024, 16'd3840, 16'd256, 12'd0);
    send_command(16'h0001, 16'h0000);
    send_command(16'h0000, 16'h0000);
    send_command(16'h8000, 16'h7FFF);
    wait_idle();
    set_geometry(16'hFFFF, 16'hFFFF, 16'hFFFF, 12'd3600);
    test_extremes();
    set_geometry(16'd1, 16'd0, 16'd1, 12'd3600);
    test_extremes();
  endtask

  // Each idle mode runs at its own setting. The settings include the reset
  // values, the largest values, small values and random values.
  task automatic test_random_phases();
    for (int mode = 0; mode < 4; mode++) begin
      tx_idle_pct  = (mode == 1) ? 62 : (mode == 3) ? 8 : 0;
      rx_stall_pct = (mode == 2) ? 62 : (mode == 3) ? 8 : 0;
      case (mode)
        0: set_geometry(16'd1024, 16'd3840, 16'd256, 12'd600);
        1: set_geometry(16'hFFFF, 16'hFFFF, 16'hFFFF, 12'd3600);
        2: set_geometry(16'd64, 16'd512, 16'd64, 12'($urandom_range(3600)));
        default: set_geometry(16'($urandom), 16'($urandom), 16'($urandom),
                              12'($urandom_range(3600)));
      endcase
      send_random(110);
      wait_idle();
    end
  endtask

  // The receiver holds off for a long stretch while commands keep coming.
  // The sender then waits until every result has been transferred.
  task automatic test_backpressure();
    tx_idle_pct = 0;
    rx_stall_pct = 20;
    set_geometry(16'd900, 16'd4000, 16'd300, 12'd1200);
    hold_req = 1'b1;
    send_random(60);
    wait_idle();
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    hold_req = 1'b0;
    cmd_bus.valid = 1'b0;
    cmd_bus.forward_speed = '0;
    cmd_bus.turn_rate = '0;
    diam_q = DIAM_RST;
    track_q = TRACK_RST;
    ratio_q = RATIO_RST;
    limit_q = LIMIT_RST;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_extremes();
    test_special_settings();
    test_random_phases();
    test_backpressure();

    if (error_count == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
